// ===== rtl/core/xesc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions for the xml escaper
// no dependencies

package xesc_pkg;

	localparam int unsigned ContW    = 3;
	localparam int unsigned QueueAw  = 2;
	localparam int unsigned IdxW     = 3;

	typedef enum logic [2:0] {
		ENT_NONE,
		ENT_AMP,
		ENT_LT,
		ENT_GT,
		ENT_APOS,
		ENT_QUOT
	} ent_e;

	// classified item, front to back
	typedef struct packed {
		ent_e       ent;
		logic [7:0] raw;
		logic       str_end;
	} desc_t;

	// entity texts, first character in the lowest byte
	localparam logic [47:0] EntAmpBytes  = 48'h00_3b_70_6d_61_26; // &amp;
	localparam logic [47:0] EntLtBytes   = 48'h00_00_3b_74_6c_26; // &lt;
	localparam logic [47:0] EntGtBytes   = 48'h00_00_3b_74_67_26; // &gt;
	localparam logic [47:0] EntAposBytes = 48'h3b_73_6f_70_61_26; // &apos;
	localparam logic [47:0] EntQuotBytes = 48'h3b_74_6f_75_71_26; // &quot;

	localparam logic [7:0] ChAmp  = 8'h26;
	localparam logic [7:0] ChLt   = 8'h3c;
	localparam logic [7:0] ChGt   = 8'h3e;
	localparam logic [7:0] ChApos = 8'h27;
	localparam logic [7:0] ChQuot = 8'h22;

	function automatic ent_e entity_of(input logic [7:0] b);
		ent_e e;
		unique case (b)
			ChAmp:   e = ENT_AMP;
			ChLt:    e = ENT_LT;
			ChGt:    e = ENT_GT;
			ChApos:  e = ENT_APOS;
			ChQuot:  e = ENT_QUOT;
			default: e = ENT_NONE;
		endcase
		return e;
	endfunction

	// continuation bytes implied by a lead byte
	function automatic logic [ContW-1:0] follow_count(input logic [7:0] b);
		logic [ContW-1:0] n;
		priority if (b < 8'hc0) n = 3'd0;
		else if (b < 8'he0)     n = 3'd1;
		else if (b < 8'hf0)     n = 3'd2;
		else if (b < 8'hf8)     n = 3'd3;
		else if (b < 8'hfc)     n = 3'd4;
		else if (b < 8'hfe)     n = 3'd5;
		else                    n = 3'd0;
		return n;
	endfunction

	// index of the last output byte of an item
	function automatic logic [IdxW-1:0] last_idx(input ent_e e);
		logic [IdxW-1:0] n;
		unique case (e)
			ENT_AMP:  n = 3'd4;
			ENT_LT:   n = 3'd3;
			ENT_GT:   n = 3'd3;
			ENT_APOS: n = 3'd5;
			ENT_QUOT: n = 3'd5;
			default:  n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] out_byte_at(input ent_e e, input logic [IdxW-1:0] idx,
	                                           input logic [7:0] raw);
		logic [47:0] txt;
		logic [5:0]  sel;
		sel = {idx, 3'b000};
		unique case (e)
			ENT_AMP:  txt = EntAmpBytes;
			ENT_LT:   txt = EntLtBytes;
			ENT_GT:   txt = EntGtBytes;
			ENT_APOS: txt = EntAposBytes;
			ENT_QUOT: txt = EntQuotBytes;
			default:  txt = {40'd0, raw};
		endcase
		return txt[sel +: 8];
	endfunction

endpackage

// ===== rtl/core/xesc_front.sv =====
`timescale 1ns / 1ps
// front part: accepts input bytes, tracks utf-8 continuation, classifies
// depends on xesc_pkg

module xesc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_end,
	input  logic                q_full,
	output logic                push,
	output xesc_pkg::desc_t     push_desc
);

	logic                          escape_en_q;
	logic [xesc_pkg::ContW-1:0]    cont_q;
	logic [xesc_pkg::ContW-1:0]    cont_next;
	xesc_pkg::ent_e                ent;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		ent       = xesc_pkg::ENT_NONE;
		cont_next = cont_q;
		if (!escape_en_q) begin
			cont_next = '0;
		end else if (cont_q != '0) begin
			cont_next = cont_q - 3'd1;
		end else begin
			ent = xesc_pkg::entity_of(in_byte);
			if (ent == xesc_pkg::ENT_NONE) begin
				cont_next = xesc_pkg::follow_count(in_byte);
			end
		end
		// end of string drops any truncated character
		if (in_end) begin
			cont_next = '0;
		end
	end

	assign push_desc = '{ent: ent, raw: in_byte, str_end: in_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_en_q <= 1'b1;
			cont_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				escape_en_q <= cfg_wr_data;
			end
			if (push) begin
				cont_q <= cont_next;
			end
		end
	end

endmodule

// ===== rtl/core/xesc_fifo.sv =====
`timescale 1ns / 1ps
// four-entry queue of classified items between front and back
// depends on xesc_pkg

module xesc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  xesc_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output xesc_pkg::desc_t head_desc
);

	localparam int unsigned Depth = 2 ** xesc_pkg::QueueAw;

	xesc_pkg::desc_t                 mem_q [Depth];
	logic [xesc_pkg::QueueAw-1:0]    wr_ptr_q;
	logic [xesc_pkg::QueueAw-1:0]    rd_ptr_q;
	logic [xesc_pkg::QueueAw:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full       = (count_q == (xesc_pkg::QueueAw + 1)'(Depth));
	assign head_valid = (count_q != '0);
	assign head_desc  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/xesc_back.sv =====
`timescale 1ns / 1ps
// back part: expands queued items into output bytes through an output register
// depends on xesc_pkg

module xesc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  xesc_pkg::desc_t head_desc,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            out_run_last,
	output logic            out_str_end
);

	logic [xesc_pkg::IdxW-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      run_last_q;
	logic                      str_end_q;
	logic                      slot_free;
	logic                      emit;
	logic                      at_last;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = head_valid && slot_free;
	assign at_last   = (idx_q == xesc_pkg::last_idx(head_desc.ent));
	assign pop       = emit && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= xesc_pkg::out_byte_at(head_desc.ent, idx_q, head_desc.raw);
			run_last_q <= at_last;
			str_end_q  <= at_last && head_desc.str_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_run_last = run_last_q;
	assign out_str_end  = str_end_q;

endmodule

// ===== rtl/core/xml_escape_utf8_stream.sv =====
`timescale 1ns / 1ps
// an input transfer passes through the queue and then the output register
// before its first output byte appears
// throughput: one byte per cycle for copied bytes while the output is not
// stalled; an entity expands into 4 to 6 output bytes, and the four-entry
// queue absorbs input meanwhile before input stalls
// reset: queue and output empty, continuation count zero, escaping enabled

module xml_escape_utf8_stream (
	input  logic        clk,
	input  logic        arst_n,
	// escape_enable register
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// input byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // string_end
	// escaped output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]  m_axis_tuser,   // [0] run_last
	output logic        m_axis_tlast    // out_string_end
);

	// front to queue
	logic            push;
	xesc_pkg::desc_t push_desc;
	logic            q_full;
	// queue to back
	logic            head_valid;
	xesc_pkg::desc_t head_desc;
	logic            pop;

	// classifies each byte and keeps the utf-8 continuation count
	xesc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_end      (s_axis_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_desc   (push_desc)
	);

	// decouples the front (one byte per cycle unless the queue is full) from byte-by-byte entity expansion
	xesc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// walks an entity one byte per transfer, pops on the last byte
	xesc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.out_run_last (m_axis_tuser[0]),
		.out_str_end  (m_axis_tlast)
	);

endmodule

// ===== rtl/core/xesc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the xml escaper, bound to the top level
// depends on xml_escape_utf8_stream

module xesc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [0:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// stalled output transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// string end only on the last byte of a run
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("string end without run end");

	// bytes of an entity before its last are never <, >, double quote or apostrophe
	a_entity_body: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata != 8'h3c
		&& m_axis_tdata != 8'h3e && m_axis_tdata != 8'h22 && m_axis_tdata != 8'h27)
		else $error("special character inside an entity");

	// output empty right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid after reset");

endmodule

bind xml_escape_utf8_stream xesc_checker u_xesc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the xml escaper on utf-8 byte streams
// depends on rtl/core/xesc_pkg.sv and rtl/core/xml_escape_utf8_stream.sv

module tb;

	// one beat of escaped output as seen on the master side
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       str_end;
	} out_beat_t;

	// directed stimulus rows: a byte transfer or a write of escape_enable
	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic [7:0] data;       // text byte, or escape_enable in bit 0
		logic       last;       // string_end
		logic       typed;      // 1: expect one copied beat holding exp_byte
		logic [7:0] exp_byte;
	} stim_row_t;

	localparam int NumRows = 28;

	// typed rows are plain copies whose output can be read straight off the input
	localparam stim_row_t DirRows [NumRows] = '{
		'{ROW_BYTE, 8'h41, 1'b0, 1'b1, 8'h41},  // ascii right after reset
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, 8'h00},  // lowest byte
		'{ROW_BYTE, 8'hff, 1'b0, 1'b1, 8'hff},  // highest byte, no continuation
		'{ROW_BYTE, xesc_pkg::ChAmp, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, xesc_pkg::ChLt,  1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, xesc_pkg::ChGt,  1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, xesc_pkg::ChApos, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, xesc_pkg::ChQuot, 1'b1, 1'b0, 8'h00}, // a six-byte entity ends a string
		'{ROW_BYTE, 8'h80, 1'b0, 1'b1, 8'h80},  // stray continuation byte
		'{ROW_BYTE, 8'hbf, 1'b0, 1'b1, 8'hbf},
		'{ROW_BYTE, 8'hc3, 1'b0, 1'b0, 8'h00},  // two-byte character
		'{ROW_BYTE, 8'ha9, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, 8'he2, 1'b0, 1'b0, 8'h00},  // specials inside a character
		'{ROW_BYTE, xesc_pkg::ChAmp, 1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, xesc_pkg::ChLt,  1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, 8'hfc, 1'b0, 1'b0, 8'h00},  // six-byte lead, cut short
		'{ROW_BYTE, 8'h80, 1'b1, 1'b0, 8'h00},
		'{ROW_BYTE, xesc_pkg::ChAmp, 1'b0, 1'b0, 8'h00},  // fresh string after truncation
		'{ROW_BYTE, 8'hf8, 1'b1, 1'b0, 8'h00},  // lead byte alone ends a string
		'{ROW_CFG,  8'h00, 1'b0, 1'b0, 8'h00},  // escaping off
		'{ROW_BYTE, xesc_pkg::ChAmp, 1'b0, 1'b1, xesc_pkg::ChAmp},
		'{ROW_BYTE, 8'he2, 1'b0, 1'b1, 8'he2},
		'{ROW_BYTE, xesc_pkg::ChLt,  1'b0, 1'b1, xesc_pkg::ChLt},
		'{ROW_CFG,  8'h01, 1'b0, 1'b0, 8'h00},  // back on in mid-string
		'{ROW_BYTE, xesc_pkg::ChGt,  1'b0, 1'b0, 8'h00},
		'{ROW_BYTE, 8'h7f, 1'b1, 1'b1, 8'h7f},
		'{ROW_BYTE, 8'hf0, 1'b0, 1'b0, 8'h00},  // four-byte lead, cut short by string end
		'{ROW_BYTE, 8'h9f, 1'b1, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
	logic       s_axis_tlast = 1'b0;    // string_end
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic [0:0] m_axis_tuser;           // [0] run_last
	logic       m_axis_tlast;           // out_string_end

	// escaper state as predicted by the testbench
	logic       escape_on = 1'b1;
	logic [2:0] tail_left = 3'd0;

	out_beat_t  expected_out_q [$];
	int         failures = 0;
	int         bytes_sent = 0;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	xml_escape_utf8_stream i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// continuation bytes announced by a utf-8 lead byte
	function automatic logic [2:0] utf8_tail_len(input logic [7:0] b);
		if (b < 8'hc0) return 3'd0;
		if (b < 8'he0) return 3'd1;
		if (b < 8'hf0) return 3'd2;
		if (b < 8'hf8) return 3'd3;
		if (b < 8'hfc) return 3'd4;
		if (b < 8'hfe) return 3'd5;
		return 3'd0;
	endfunction

	// replacement text of an xml special character, empty for all others
	function automatic string entity_text(input logic [7:0] b);
		case (b)
			xesc_pkg::ChAmp:   return "&amp;";
			xesc_pkg::ChLt:    return "&lt;";
			xesc_pkg::ChGt:    return "&gt;";
			xesc_pkg::ChApos:  return "&apos;";
			xesc_pkg::ChQuot:  return "&quot;";
			default:           return "";
		endcase
	endfunction

	// advance the predicted state for one input byte; with record set,
	// queue the output beats it must produce
	function automatic void escape_byte(input logic [7:0] b, input logic str_end,
	                                    input bit record);
		string      ent;
		logic [7:0] beats [$];
		out_beat_t  beat;
		if (!escape_on) begin
			beats.push_back(b);
			tail_left = 3'd0;
		end else if (tail_left != 3'd0) begin
			// inside a character: copied raw, even a special character
			beats.push_back(b);
			tail_left = tail_left - 3'd1;
		end else begin
			ent = entity_text(b);
			if (ent.len() != 0) begin
				for (int i = 0; i < ent.len(); i++) beats.push_back(ent[i]);
			end else begin
				beats.push_back(b);
				tail_left = utf8_tail_len(b);
			end
		end
		// end of string drops whatever is left of a truncated character
		if (str_end) tail_left = 3'd0;
		if (record) begin
			foreach (beats[k]) begin
				beat.data     = beats[k];
				beat.run_last = (k == beats.size() - 1);
				beat.str_end  = (k == beats.size() - 1) && str_end;
				expected_out_q.push_back(beat);
			end
		end
	endfunction

	// one input transfer, preceded by random sender idle cycles
	task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
	                         input logic [7:0] exp_b);
		out_beat_t beat;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= l;
		escape_byte(d, l, !typed);
		if (typed) begin
			beat.data     = exp_b;
			beat.run_last = 1'b1;
			beat.str_end  = l;
			expected_out_q.push_back(beat);
		end
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// escape_enable is only written once the output has fully drained
	task automatic write_escape_enable(input logic v);
		s_axis_tvalid <= 1'b0;
		while (expected_out_q.size() != 0) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		escape_on = v;
	endtask

	function automatic logic [7:0] pick_special();
		case ($urandom_range(4))
			0:       return xesc_pkg::ChAmp;
			1:       return xesc_pkg::ChLt;
			2:       return xesc_pkg::ChGt;
			3:       return xesc_pkg::ChApos;
			default: return xesc_pkg::ChQuot;
		endcase
	endfunction

	// one random character: mostly well-formed utf-8 with random content,
	// some truncated characters, some raw noise bytes
	task automatic send_random_char();
		logic [7:0] seq [$];
		int         kind;
		int         len;
		int         cut;
		logic       end_str;
		kind = $urandom_range(99);
		if (kind < 25) begin
			seq.push_back(pick_special());
		end else if (kind < 45) begin
			seq.push_back(8'($urandom_range(127)));
		end else if (kind < 90) begin
			len = $urandom_range(2, 6);
			case (len)
				2:       seq.push_back(8'hc0 | 8'($urandom_range(31)));
				3:       seq.push_back(8'he0 | 8'($urandom_range(15)));
				4:       seq.push_back(8'hf0 | 8'($urandom_range(7)));
				5:       seq.push_back(8'hf8 | 8'($urandom_range(3)));
				default: seq.push_back(8'hfc | 8'($urandom_range(1)));
			endcase
			for (int i = 1; i < len; i++) begin
				// now and then a special or any byte where a continuation belongs
				case ($urandom_range(9))
					0:       seq.push_back(pick_special());
					1:       seq.push_back(8'($urandom_range(255)));
					default: seq.push_back(8'h80 | 8'($urandom_range(63)));
				endcase
			end
		end else begin
			seq.push_back(8'($urandom_range(255)));
		end
		// truncated character: string ends before its last continuation
		cut = seq.size();
		if (kind >= 80 && kind < 90) cut = $urandom_range(1, seq.size() - 1);
		end_str = (cut < seq.size()) || ($urandom_range(5) == 0);
		for (int i = 0; i < cut; i++)
			send_byte(seq[i], end_str && (i == cut - 1), 1'b0, 8'h00);
	endtask

	// receiver stalls at the rate of the current phase
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// output checker: every transfer against the oldest expected beat
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_out_q.size() == 0) begin
				$error("unexpected output transfer: out_byte %h", m_axis_tdata);
				failures++;
			end else begin
				want = expected_out_q.pop_front();
				if (m_axis_tdata !== want.data) begin
					$error("out_byte: expected %h, actual %h", want.data, m_axis_tdata);
					failures++;
				end
				if (m_axis_tuser[0] !== want.run_last) begin
					$error("run_last: expected %b, actual %b", want.run_last,
					       m_axis_tuser[0]);
					failures++;
				end
				if (m_axis_tlast !== want.str_end) begin
					$error("out_string_end: expected %b, actual %b", want.str_end,
					       m_axis_tlast);
					failures++;
				end
			end
		end
	end

	// main sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no idling
		foreach (DirRows[r]) begin
			if (DirRows[r].kind == ROW_CFG) begin
				write_escape_enable(DirRows[r].data[0]);
			end else begin
				send_byte(DirRows[r].data, DirRows[r].last, DirRows[r].typed,
				          DirRows[r].exp_byte);
			end
		end

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
				default: begin src_idle_pct = 19; sink_stall_pct = 19; end
			endcase
			// each half starts from a drained block with a freshly written escape setting
			for (int half = 0; half < 2; half++) begin
				int start;
				if (ph == 0 && half == 0) write_escape_enable(1'b1);
				else if (ph == 1 && half == 0) write_escape_enable(1'b0);
				else write_escape_enable($urandom_range(3) != 0);
				start = bytes_sent;
				while (bytes_sent - start < 8) send_random_char();
			end
		end

		// drain, then watch a little longer for stray output
		s_axis_tvalid <= 1'b0;
		while (expected_out_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_out_q.size() == 0) begin
			$display("xml_escape_utf8_stream regression: pass");
		end else begin
			$display("xml_escape_utf8_stream regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("xml_escape_utf8_stream regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/xesc_pkg.sv
rtl/core/xesc_front.sv
rtl/core/xesc_fifo.sv
rtl/core/xesc_back.sv
rtl/core/xml_escape_utf8_stream.sv
rtl/core/xesc_checker.sv
dv/tb.sv
